FILE: rtl/core/i2cm_pkg.sv
`timescale 1ns / 1ps

package i2cm_pkg;

	// request codes on the command channel
	localparam logic [2:0] REQ_TICK  = 3'd0;
	localparam logic [2:0] REQ_START = 3'd1;
	localparam logic [2:0] REQ_STOP  = 3'd2;
	localparam logic [2:0] REQ_WRITE = 3'd3;
	localparam logic [2:0] REQ_READ  = 3'd4;

	localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

	// command queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_START,
		CMD_STOP,
		CMD_WRITE,
		CMD_READ
	} cmd_t;

	typedef struct packed {
		logic [2:0] req_type;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       sda_in;
	} req_t;

	typedef struct packed {
		logic       scl;
		logic       sda_out;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic       ack_error;
		logic [7:0] rx_byte;
	} rsp_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       sda_in;
	} qent_t;

endpackage

FILE: rtl/core/i2cm_front.sv
`timescale 1ns / 1ps

module i2cm_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	input  i2cm_pkg::req_t       cmd,
	output logic                 q_valid,
	output i2cm_pkg::qent_t      q_entry,
	input  logic                 q_pop
);

	i2cm_pkg::qent_t                 mem_q [i2cm_pkg::QDEPTH];
	logic [i2cm_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [i2cm_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [i2cm_pkg::QCNT_W-1:0]     cnt_q;
	i2cm_pkg::qent_t                 ent_d;
	logic                            push;

	// unused request codes behave as a plain tick
	always_comb begin
		ent_d.tx_byte  = cmd.tx_byte;
		ent_d.send_ack = cmd.send_ack;
		ent_d.sda_in   = cmd.sda_in;
		unique case (cmd.req_type)
			i2cm_pkg::REQ_START: ent_d.cmd = i2cm_pkg::CMD_START;
			i2cm_pkg::REQ_STOP:  ent_d.cmd = i2cm_pkg::CMD_STOP;
			i2cm_pkg::REQ_WRITE: ent_d.cmd = i2cm_pkg::CMD_WRITE;
			i2cm_pkg::REQ_READ:  ent_d.cmd = i2cm_pkg::CMD_READ;
			default:             ent_d.cmd = i2cm_pkg::CMD_NONE;
		endcase
	end

	assign cmd_ready = (cnt_q != i2cm_pkg::QCNT_W'(i2cm_pkg::QDEPTH));
	assign push      = cmd_valid && cmd_ready;
	assign q_valid   = (cnt_q != '0);
	assign q_entry   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= ent_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == i2cm_pkg::QPTR_W'(i2cm_pkg::QDEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == i2cm_pkg::QPTR_W'(i2cm_pkg::QDEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= i2cm_pkg::QCNT_W'(i2cm_pkg::QDEPTH))
		else $error("command queue count overflow");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from empty command queue");
`endif

endmodule

FILE: rtl/core/i2cm_back.sv
`timescale 1ns / 1ps

module i2cm_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [7:0]           cfg_wdata,
	input  logic                 q_valid,
	input  i2cm_pkg::qent_t      q_entry,
	output logic                 q_pop,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output i2cm_pkg::rsp_t       rsp
);

	localparam logic [4:0] PH_IDLE  = 5'd0;
	localparam logic [4:0] PH_ST1   = 5'd1;
	localparam logic [4:0] PH_ST2   = 5'd2;
	localparam logic [4:0] PH_ST3   = 5'd3;
	localparam logic [4:0] PH_SP1   = 5'd4;
	localparam logic [4:0] PH_SP2   = 5'd5;
	localparam logic [4:0] PH_SP3   = 5'd6;
	localparam logic [4:0] PH_WBIT  = 5'd7;
	localparam logic [4:0] PH_WHI   = 5'd8;
	localparam logic [4:0] PH_WLO   = 5'd9;
	localparam logic [4:0] PH_WREL  = 5'd10;
	localparam logic [4:0] PH_WSAMP = 5'd11;
	localparam logic [4:0] PH_RHI   = 5'd12;
	localparam logic [4:0] PH_RLO   = 5'd13;
	localparam logic [4:0] PH_KDRV  = 5'd14;
	localparam logic [4:0] PH_KLO1  = 5'd15;
	localparam logic [4:0] PH_KHI   = 5'd16;
	localparam logic [4:0] PH_KLO2  = 5'd17;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	logic [7:0]        ack_timeout_q;
	logic [4:0]        phase_q,    phase_d;
	logic [3:0]        bit_cnt_q,  bit_cnt_d;
	logic [7:0]        shift_q,    shift_d;
	logic [7:0]        wait_cnt_q, wait_cnt_d;
	logic              scl_q,      scl_d;
	logic              sda_q,      sda_d;
	logic              drv_q,      drv_d;
	logic              ack_sel_q,  ack_sel_d;
	logic              err_pend_q, err_pend_d;
	logic [7:0]        rx_last_q,  rx_last_d;
	logic              done_d;
	logic              err_d;
	logic [3:0]        bit_inc;
	logic              rsp_valid_q;
	i2cm_pkg::rsp_t    rsp_q;

	assign q_pop     = q_valid && (!rsp_valid_q || rsp_ready);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign bit_inc   = bit_cnt_q + 1'b1;

	always_comb begin
		phase_d    = phase_q;
		bit_cnt_d  = bit_cnt_q;
		shift_d    = shift_q;
		wait_cnt_d = wait_cnt_q;
		scl_d      = scl_q;
		sda_d      = sda_q;
		drv_d      = drv_q;
		ack_sel_d  = ack_sel_q;
		err_pend_d = err_pend_q;
		rx_last_d  = rx_last_q;
		done_d     = 1'b0;
		err_d      = 1'b0;
		unique case (phase_q)
			PH_ST1: begin scl_d = 1'b1; phase_d = PH_ST2; end
			PH_ST2: begin sda_d = 1'b0; phase_d = PH_ST3; end
			PH_ST3: begin scl_d = 1'b0; phase_d = PH_IDLE; done_d = 1'b1; end
			PH_SP1: begin sda_d = 1'b0; phase_d = PH_SP2; end
			PH_SP2: begin scl_d = 1'b1; phase_d = PH_SP3; end
			PH_SP3: begin
				sda_d      = 1'b1;
				phase_d    = PH_IDLE;
				done_d     = 1'b1;
				err_d      = err_pend_q;
				err_pend_d = 1'b0;
			end
			PH_WBIT: begin
				sda_d   = shift_q[7];
				shift_d = {shift_q[6:0], 1'b0};
				phase_d = PH_WHI;
			end
			PH_WHI: begin scl_d = 1'b1; phase_d = PH_WLO; end
			PH_WLO: begin
				scl_d     = 1'b0;
				bit_cnt_d = bit_inc;
				phase_d   = (bit_inc >= BITS_PER_BYTE) ? PH_WREL : PH_WBIT;
			end
			PH_WREL: begin
				drv_d      = 1'b0;
				scl_d      = 1'b1;
				wait_cnt_d = '0;
				phase_d    = PH_WSAMP;
			end
			PH_WSAMP: begin
				if (!q_entry.sda_in) begin
					scl_d   = 1'b0;
					phase_d = PH_IDLE;
					done_d  = 1'b1;
				end else if (wait_cnt_q >= ack_timeout_q) begin
					// no acknowledge in time: abort through a stop
					drv_d      = 1'b1;
					scl_d      = 1'b0;
					err_pend_d = 1'b1;
					phase_d    = PH_SP1;
				end else begin
					wait_cnt_d = wait_cnt_q + 1'b1;
				end
			end
			PH_RHI: begin scl_d = 1'b1; phase_d = PH_RLO; end
			PH_RLO: begin
				shift_d   = {shift_q[6:0], q_entry.sda_in};
				scl_d     = 1'b0;
				bit_cnt_d = bit_inc;
				phase_d   = (bit_inc >= BITS_PER_BYTE) ? PH_KDRV : PH_RHI;
			end
			PH_KDRV: begin
				drv_d   = 1'b1;
				sda_d   = ~ack_sel_q;
				phase_d = PH_KLO1;
			end
			PH_KLO1: begin scl_d = 1'b0; phase_d = PH_KHI; end
			PH_KHI:  begin scl_d = 1'b1; phase_d = PH_KLO2; end
			PH_KLO2: begin
				scl_d     = 1'b0;
				rx_last_d = shift_q;
				phase_d   = PH_IDLE;
				done_d    = 1'b1;
			end
			default: begin
				phase_d = PH_IDLE;
				unique case (q_entry.cmd)
					i2cm_pkg::CMD_START: begin
						drv_d   = 1'b1;
						sda_d   = 1'b1;
						phase_d = PH_ST1;
					end
					i2cm_pkg::CMD_STOP: begin
						drv_d      = 1'b1;
						scl_d      = 1'b0;
						err_pend_d = 1'b0;
						phase_d    = PH_SP1;
					end
					i2cm_pkg::CMD_WRITE: begin
						drv_d     = 1'b1;
						scl_d     = 1'b0;
						shift_d   = q_entry.tx_byte;
						bit_cnt_d = '0;
						phase_d   = PH_WBIT;
					end
					i2cm_pkg::CMD_READ: begin
						drv_d     = 1'b0;
						scl_d     = 1'b0;
						shift_d   = '0;
						bit_cnt_d = '0;
						ack_sel_d = q_entry.send_ack;
						phase_d   = PH_RHI;
					end
					default: ;
				endcase
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_timeout_q <= i2cm_pkg::ACK_TIMEOUT_RST;
			phase_q       <= PH_IDLE;
			bit_cnt_q     <= '0;
			shift_q       <= '0;
			wait_cnt_q    <= '0;
			scl_q         <= 1'b1;
			sda_q         <= 1'b1;
			drv_q         <= 1'b1;
			ack_sel_q     <= 1'b0;
			err_pend_q    <= 1'b0;
			rx_last_q     <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				ack_timeout_q <= cfg_wdata;
			end
			if (q_pop) begin
				phase_q    <= phase_d;
				bit_cnt_q  <= bit_cnt_d;
				shift_q    <= shift_d;
				wait_cnt_q <= wait_cnt_d;
				scl_q      <= scl_d;
				sda_q      <= sda_d;
				drv_q      <= drv_d;
				ack_sel_q  <= ack_sel_d;
				err_pend_q <= err_pend_d;
				rx_last_q  <= rx_last_d;
			end
			if (q_pop) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			rsp_q.scl       <= scl_d;
			rsp_q.sda_out   <= sda_d;
			rsp_q.sda_drive <= drv_d;
			rsp_q.busy_res  <= (phase_d != PH_IDLE);
			rsp_q.done_res  <= done_d;
			rsp_q.ack_error <= err_d;
			rsp_q.rx_byte   <= rx_last_d;
		end
	end

`ifndef SYNTHESIS
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.done_res |-> !rsp_q.busy_res)
		else $error("done beat reports busy");

	a_err_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.ack_error |-> rsp_q.done_res)
		else $error("ack error without done");

	a_bit_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		bit_cnt_q <= BITS_PER_BYTE)
		else $error("bit counter past a byte");

	a_wait_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_WSAMP |-> wait_cnt_q <= ack_timeout_q)
		else $error("acknowledge wait past timeout");
`endif

endmodule

FILE: rtl/core/i2c_master_bit_engine.sv
`timescale 1ns / 1ps

// I2C master bit engine. Each command beat is one bus tick and yields exactly one
// response beat holding the SCL/SDA levels after that tick plus busy, done, ack
// error and the last received byte. Start, stop, write-byte and read-byte commands
// are taken only while idle; a command arriving mid-sequence just advances it.
// One beat per clock is sustained in both directions while the response side is
// ready: the front classifies commands into a four-entry queue and the back
// sequencer takes one queue entry per cycle into a response register, so each
// beat passes through the queue and then the response register. The queue lets
// the command side keep streaming for up to four beats while the response side
// is stalled. ack_timeout is written through cfg_we/cfg_wdata and must only
// change while idle.

module i2c_master_bit_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_wdata,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  i2cm_pkg::req_t    cmd,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output i2cm_pkg::rsp_t    rsp
);

	logic               q_valid;
	logic               q_pop;
	i2cm_pkg::qent_t    q_entry;

	i2cm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.q_pop     (q_pop)
	);

	i2cm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.q_pop     (q_pop),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

FILE: dv/i2c_master_bit_engine_tb.sv
`timescale 1ns / 1ps

module i2c_master_bit_engine_tb;

	// request codes with no meaning to the block
	localparam logic [2:0] REQ_SPARE_LO = 3'd5;
	localparam logic [2:0] REQ_SPARE_HI = 3'd7;

	localparam int DIR_ROWS = 25;
	localparam int N_PHASES = 8;
	localparam longint LIMIT_NS = 4_000_000;

	// random traffic: ack_timeout (or upper bound of a draw), beats, idling per side
	localparam logic [7:0] PH_REG [N_PHASES] =
		'{8'd3, 8'd0, 8'd255, 8'd1, 8'd7, 8'd15, 8'd255, 8'd2};
	localparam bit PH_DRAW [N_PHASES] = '{0, 0, 0, 0, 0, 1, 1, 0};
	localparam int unsigned PH_BEATS [N_PHASES] = '{50, 50, 60, 50, 50, 50, 40, 40};
	localparam bit PH_GAPS [N_PHASES] = '{0, 1, 1, 1, 0, 1, 1, 0};
	localparam bit PH_STALLS [N_PHASES] = '{0, 1, 1, 0, 1, 1, 1, 0};

	localparam i2cm_pkg::rsp_t IDLE_LINES = '{scl: 1'b1, sda_out: 1'b1, sda_drive: 1'b1,
		busy_res: 1'b0, done_res: 1'b0, ack_error: 1'b0, rx_byte: 8'h00};

	typedef enum logic [4:0] {
		BUS_IDLE,
		ST_SCL_HI, ST_SDA_LO, ST_SCL_LO,
		SP_SDA_LO, SP_SCL_HI, SP_SDA_HI,
		WR_BIT, WR_SCL_HI, WR_SCL_LO, WR_RELEASE, WR_ACK_SAMPLE,
		RD_SCL_HI, RD_SAMPLE,
		AK_DRIVE, AK_SCL_LO1, AK_SCL_HI, AK_SCL_LO2
	} bus_phase_t;

	typedef struct packed {
		logic           set_reg;
		logic [7:0]     reg_val;
		i2cm_pkg::req_t beat;
		logic [8:0]     reps;
		logic           fixed;
		i2cm_pkg::rsp_t lines;
	} dir_row_t;

	logic           clk;
	logic           arst_n;
	logic           cfg_we;
	logic [7:0]     cfg_wdata;
	logic           cmd_valid;
	logic           cmd_ready;
	i2cm_pkg::req_t cmd;
	logic           rsp_valid;
	logic           rsp_ready;
	i2cm_pkg::rsp_t rsp;

	i2c_master_bit_engine uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// bus engine mirror
	bus_phase_t p_phase;
	logic [3:0] p_bits;
	logic [7:0] p_shift;
	logic [7:0] p_waits;
	logic       p_scl;
	logic       p_sda;
	logic       p_drive;
	logic       p_ack;
	logic       p_err;
	logic [7:0] p_rx;
	logic [7:0] p_timeout;

	i2cm_pkg::rsp_t lines_due [$];
	bit             beat_fixed;
	i2cm_pkg::rsp_t beat_fixed_lines;
	bit             cmd_gaps;
	bit             rsp_stalls;

	int unsigned mismatches;
	int unsigned beats_checked;
	int unsigned n_start, n_stop, n_write, n_read, n_noack, n_settings;

	task automatic reset_model();
		p_phase   = BUS_IDLE;
		p_bits    = '0;
		p_shift   = '0;
		p_waits   = '0;
		p_scl     = 1'b1;
		p_sda     = 1'b1;
		p_drive   = 1'b1;
		p_ack     = 1'b0;
		p_err     = 1'b0;
		p_rx      = '0;
		p_timeout = i2cm_pkg::ACK_TIMEOUT_RST;
	endtask

	// one bus tick: advance the mirror and return the line state after it
	function automatic i2cm_pkg::rsp_t bus_tick(input i2cm_pkg::req_t r);
		logic           done;
		logic           err;
		logic [8:0]     tries;
		i2cm_pkg::rsp_t o;
		done = 1'b0;
		err  = 1'b0;
		case (p_phase)
			ST_SCL_HI: begin p_scl = 1'b1; p_phase = ST_SDA_LO; end
			ST_SDA_LO: begin p_sda = 1'b0; p_phase = ST_SCL_LO; end
			ST_SCL_LO: begin p_scl = 1'b0; p_phase = BUS_IDLE; done = 1'b1; end
			SP_SDA_LO: begin p_sda = 1'b0; p_phase = SP_SCL_HI; end
			SP_SCL_HI: begin p_scl = 1'b1; p_phase = SP_SDA_HI; end
			SP_SDA_HI: begin
				p_sda = 1'b1;
				p_phase = BUS_IDLE;
				done = 1'b1;
				err = p_err;
				p_err = 1'b0;
			end
			WR_BIT: begin
				p_sda = p_shift[7];
				p_shift = {p_shift[6:0], 1'b0};
				p_phase = WR_SCL_HI;
			end
			WR_SCL_HI: begin p_scl = 1'b1; p_phase = WR_SCL_LO; end
			WR_SCL_LO: begin
				p_scl = 1'b0;
				p_bits = p_bits + 4'd1;
				p_phase = (p_bits >= 4'd8) ? WR_RELEASE : WR_BIT;
			end
			WR_RELEASE: begin
				p_drive = 1'b0;
				p_scl = 1'b1;
				p_waits = '0;
				p_phase = WR_ACK_SAMPLE;
			end
			WR_ACK_SAMPLE: begin
				if (!r.sda_in) begin
					p_scl = 1'b0;
					p_phase = BUS_IDLE;
					done = 1'b1;
				end else begin
					tries = {1'b0, p_waits} + 9'd1;
					if (tries > {1'b0, p_timeout}) begin
						// give up: drive a stop and report on its last tick
						p_drive = 1'b1;
						p_scl = 1'b0;
						p_err = 1'b1;
						p_phase = SP_SDA_LO;
						n_noack++;
					end else begin
						p_waits = tries[7:0];
					end
				end
			end
			RD_SCL_HI: begin p_scl = 1'b1; p_phase = RD_SAMPLE; end
			RD_SAMPLE: begin
				p_shift = {p_shift[6:0], r.sda_in};
				p_scl = 1'b0;
				p_bits = p_bits + 4'd1;
				p_phase = (p_bits >= 4'd8) ? AK_DRIVE : RD_SCL_HI;
			end
			AK_DRIVE: begin
				p_drive = 1'b1;
				p_sda = ~p_ack;
				p_phase = AK_SCL_LO1;
			end
			AK_SCL_LO1: begin p_scl = 1'b0; p_phase = AK_SCL_HI; end
			AK_SCL_HI: begin p_scl = 1'b1; p_phase = AK_SCL_LO2; end
			AK_SCL_LO2: begin
				p_scl = 1'b0;
				p_rx = p_shift;
				p_phase = BUS_IDLE;
				done = 1'b1;
			end
			default: begin
				p_phase = BUS_IDLE;
				case (r.req_type)
					i2cm_pkg::REQ_START: begin
						p_drive = 1'b1;
						p_sda = 1'b1;
						p_phase = ST_SCL_HI;
						n_start++;
					end
					i2cm_pkg::REQ_STOP: begin
						p_drive = 1'b1;
						p_scl = 1'b0;
						p_err = 1'b0;
						p_phase = SP_SDA_LO;
						n_stop++;
					end
					i2cm_pkg::REQ_WRITE: begin
						p_drive = 1'b1;
						p_scl = 1'b0;
						p_shift = r.tx_byte;
						p_bits = '0;
						p_phase = WR_BIT;
						n_write++;
					end
					i2cm_pkg::REQ_READ: begin
						p_drive = 1'b0;
						p_scl = 1'b0;
						p_shift = '0;
						p_bits = '0;
						p_ack = r.send_ack;
						p_phase = RD_SCL_HI;
						n_read++;
					end
					default: ;
				endcase
			end
		endcase
		o.scl       = p_scl;
		o.sda_out   = p_sda;
		o.sda_drive = p_drive;
		o.busy_res  = (p_phase != BUS_IDLE);
		o.done_res  = done;
		o.ack_error = err;
		o.rx_byte   = p_rx;
		return o;
	endfunction

	function automatic void check_field(input string what, input logic [7:0] want,
		input logic [7:0] got);
		if (want !== got) begin
			if (mismatches < 100)
				$display("%0t ns: %s expected %0h, got %0h", $time, what, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		i2cm_pkg::rsp_t want;
		i2cm_pkg::rsp_t pred;
		if (rsp_valid && rsp_ready) begin
			if (lines_due.size() == 0) begin
				if (mismatches < 100)
					$display("%0t ns: response beat expected none, got %h", $time, rsp);
				mismatches++;
			end else begin
				want = lines_due.pop_front();
				check_field("scl", want.scl, rsp.scl);
				check_field("sda_out", want.sda_out, rsp.sda_out);
				check_field("sda_drive", want.sda_drive, rsp.sda_drive);
				check_field("busy_res", want.busy_res, rsp.busy_res);
				check_field("done_res", want.done_res, rsp.done_res);
				check_field("ack_error", want.ack_error, rsp.ack_error);
				check_field("rx_byte", want.rx_byte, rsp.rx_byte);
				beats_checked++;
			end
		end
		if (cfg_we)
			p_timeout = cfg_wdata;
		if (cmd_valid && cmd_ready) begin
			pred = bus_tick(cmd);
			lines_due.push_back(beat_fixed ? beat_fixed_lines : pred);
		end
	end

	// mostly no gap, some short, a few long
	function automatic int unsigned draw_gap(input bit on);
		int unsigned roll;
		roll = $urandom_range(99);
		if (!on || roll < 60)
			return 0;
		if (roll < 95)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	initial begin
		int unsigned hold;
		hold = 0;
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold != 0) begin
				rsp_ready <= 1'b0;
				hold--;
			end else begin
				rsp_ready <= 1'b1;
				hold = draw_gap(rsp_stalls);
			end
		end
	end

	// entered and left at a falling edge; valid stays up across back-to-back beats
	task automatic push_beat(input i2cm_pkg::req_t r);
		int unsigned gap;
		gap = draw_gap(cmd_gaps);
		if (gap != 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd <= r;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// finish the running sequence, drain, then write the register
	task automatic set_timeout(input logic [7:0] v);
		i2cm_pkg::req_t r;
		r.req_type = i2cm_pkg::REQ_TICK;
		r.tx_byte  = 8'h00;
		r.send_ack = 1'b0;
		r.sda_in   = 1'b0;
		while (p_phase != BUS_IDLE)
			push_beat(r);
		cmd_valid <= 1'b0;
		while (lines_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	task automatic random_traffic(input int unsigned n_beats);
		int unsigned    sent;
		int unsigned    highs;
		int unsigned    plan;
		int unsigned    lim;
		int unsigned    roll;
		i2cm_pkg::req_t r;
		sent = 0;
		while (sent < n_beats) begin
			r.tx_byte  = 8'($urandom);
			r.send_ack = 1'($urandom);
			r.sda_in   = 1'($urandom);
			roll = $urandom_range(99);
			if (roll < 8) begin
				// idle noise, not counted
				r.req_type = (roll < 4) ? i2cm_pkg::REQ_TICK
					: 3'($urandom_range(REQ_SPARE_HI, REQ_SPARE_LO));
				push_beat(r);
				continue;
			end
			r.req_type = 3'($urandom_range(i2cm_pkg::REQ_READ, i2cm_pkg::REQ_START));
			// number of high acknowledge samples before SDA goes low
			lim = p_timeout;
			roll = $urandom_range(99);
			if (roll < 10)
				plan = lim + 1;
			else if (roll < 20)
				plan = lim;
			else if (roll < 30)
				plan = $urandom_range(lim);
			else
				plan = $urandom_range(lim < 3 ? lim : 3);
			push_beat(r);
			sent++;
			highs = 0;
			while (p_phase != BUS_IDLE) begin
				r.tx_byte  = 8'($urandom);
				r.send_ack = 1'($urandom);
				r.sda_in   = 1'($urandom);
				r.req_type = ($urandom_range(9) == 0)
					? 3'($urandom_range(REQ_SPARE_HI, i2cm_pkg::REQ_START))
					: i2cm_pkg::REQ_TICK;
				if (p_phase == WR_ACK_SAMPLE) begin
					r.sda_in = (highs < plan);
					highs++;
				end
				push_beat(r);
				sent++;
			end
		end
	endtask

	function automatic dir_row_t beat_row(input logic [2:0] req, input logic [7:0] txb,
		input logic ack, input logic sda, input int unsigned reps);
		dir_row_t row;
		row = '0;
		row.beat.req_type = req;
		row.beat.tx_byte  = txb;
		row.beat.send_ack = ack;
		row.beat.sda_in   = sda;
		row.reps = reps[8:0];
		return row;
	endfunction

	function automatic dir_row_t idle_row(input logic [2:0] req, input logic [7:0] txb,
		input logic ack, input logic sda);
		dir_row_t row;
		row = beat_row(req, txb, ack, sda, 1);
		row.fixed = 1'b1;
		row.lines = IDLE_LINES;
		return row;
	endfunction

	function automatic dir_row_t reg_row(input logic [7:0] v);
		dir_row_t row;
		row = '0;
		row.set_reg = 1'b1;
		row.reg_val = v;
		return row;
	endfunction

	initial begin
		#(LIMIT_NS);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		dir_row_t dir_tab [DIR_ROWS];
		logic [7:0] reg_v;
		reset_model();
		mismatches = 0;
		beats_checked = 0;
		n_start = 0;
		n_stop = 0;
		n_write = 0;
		n_read = 0;
		n_noack = 0;
		n_settings = 0;
		beat_fixed = 1'b0;
		beat_fixed_lines = IDLE_LINES;
		cmd_gaps = 1'b1;
		rsp_stalls = 1'b1;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 8'h00;
		cmd_valid = 1'b0;
		cmd = '0;

		dir_tab = '{
			idle_row(i2cm_pkg::REQ_TICK, 8'h00, 1'b0, 1'b0),
			idle_row(REQ_SPARE_HI, 8'hFF, 1'b1, 1'b1),
			idle_row(REQ_SPARE_LO, 8'h00, 1'b0, 1'b1),
			beat_row(i2cm_pkg::REQ_START, 8'h3C, 1'b0, 1'b1, 1),
			beat_row(i2cm_pkg::REQ_TICK, 8'h00, 1'b0, 1'b1, 3),
			beat_row(i2cm_pkg::REQ_WRITE, 8'hFF, 1'b0, 1'b1, 1),
			// commands while busy are ignored
			beat_row(i2cm_pkg::REQ_START, 8'h00, 1'b1, 1'b1, 4),
			beat_row(i2cm_pkg::REQ_TICK, 8'h00, 1'b0, 1'b1, 21),
			beat_row(i2cm_pkg::REQ_TICK, 8'h00, 1'b0, 1'b1, 2),
			beat_row(i2cm_pkg::REQ_TICK, 8'h00, 1'b0, 1'b0, 1),
			beat_row(i2cm_pkg::REQ_WRITE, 8'h00, 1'b1, 1'b0, 1),
			beat_row(i2cm_pkg::REQ_TICK, 8'hFF, 1'b1, 1'b0, 26),
			beat_row(i2cm_pkg::REQ_READ, 8'h00, 1'b1, 1'b1, 1),
			beat_row(i2cm_pkg::REQ_TICK, 8'h00, 1'b0, 1'b1, 8),
			beat_row(i2cm_pkg::REQ_TICK, 8'h00, 1'b0, 1'b0, 8),
			beat_row(i2cm_pkg::REQ_STOP, 8'h00, 1'b0, 1'b0, 4),
			beat_row(i2cm_pkg::REQ_READ, 8'hFF, 1'b0, 1'b0, 1),
			beat_row(i2cm_pkg::REQ_TICK, 8'h00, 1'b0, 1'b1, 20),
			beat_row(i2cm_pkg::REQ_STOP, 8'h00, 1'b0, 1'b0, 1),
			beat_row(i2cm_pkg::REQ_TICK, 8'h00, 1'b0, 1'b0, 3),
			reg_row(8'h00),
			// first high sample already exceeds a zero timeout
			beat_row(i2cm_pkg::REQ_WRITE, 8'h5A, 1'b0, 1'b1, 1),
			beat_row(i2cm_pkg::REQ_TICK, 8'h00, 1'b0, 1'b1, 29),
			beat_row(i2cm_pkg::REQ_WRITE, 8'h81, 1'b0, 1'b0, 1),
			beat_row(i2cm_pkg::REQ_TICK, 8'h00, 1'b0, 1'b0, 26)
		};

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (dir_tab[i].set_reg) begin
				set_timeout(dir_tab[i].reg_val);
			end else begin
				beat_fixed = dir_tab[i].fixed;
				beat_fixed_lines = dir_tab[i].lines;
				repeat (dir_tab[i].reps) push_beat(dir_tab[i].beat);
				beat_fixed = 1'b0;
			end
		end

		for (int ph = 0; ph < N_PHASES; ph++) begin
			reg_v = PH_DRAW[ph] ? 8'($urandom_range(PH_REG[ph])) : PH_REG[ph];
			set_timeout(reg_v);
			cmd_gaps = PH_GAPS[ph];
			rsp_stalls = PH_STALLS[ph];
			random_traffic(PH_BEATS[ph]);
		end

		cmd_valid <= 1'b0;
		while (lines_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Bus traffic: %0d starts, %0d stops, %0d writes, %0d reads",
			n_start, n_stop, n_write, n_read);
		$display("under %0d timeout settings; %0d no-ack aborts, %0d beats checked.",
			n_settings, n_noack, beats_checked);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
